FILE: design/adcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcf_pkg
// Shared types and constants for the converter frame unpacker and the
// per-channel hysteresis trigger.
// ----------------------------------------------------------------------------
package adcf_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 14;
  localparam int THRESH_BITS  = 14;
  localparam int WORD_BITS    = 32;
  localparam int CFG_IDX_BITS = 1;
  localparam int CH_BITS      = 2;   // bank bit plus lane bit

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [THRESH_BITS-1:0] thresh_t;
  typedef logic [CH_BITS-1:0]            chan_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESH_HIGH = 1'b0,
    REG_THRESH_LOW  = 1'b1
  } cfg_reg_e;

  localparam thresh_t THRESH_HIGH_RST = THRESH_BITS'(1638);
  localparam thresh_t THRESH_LOW_RST  = THRESH_BITS'(819);

  // Current state of one channel as seen by the trigger logic.
  typedef struct packed {
    logic    armed;
    sample_t prev;
  } chan_state_t;

  // Decision of the trigger logic for one sample.
  typedef struct packed {
    logic fire;
    logic armed_d;
  } trig_res_t;

endpackage

`default_nettype wire

FILE: design/adcf_trig_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcf_trig_cell
// Hysteresis trigger decision for one channel and one new sample.
// ----------------------------------------------------------------------------
module adcf_trig_cell
  import adcf_pkg::*;
(
  input  var chan_state_t state_i,
  input  var sample_t     sample_i,
  input  var thresh_t     thresh_high_i,
  input  var thresh_t     thresh_low_i,
  output trig_res_t       res_o
);

  logic rise;

  // Fire on an unarmed channel crossing upward; otherwise disarm below low.
  assign rise = !state_i.armed && (state_i.prev < thresh_high_i)
                && (sample_i >= thresh_high_i);

  always_comb begin
    res_o.fire    = rise;
    res_o.armed_d = state_i.armed;
    if (rise) begin
      res_o.armed_d = 1'b1;
    end else if (sample_i < thresh_low_i) begin
      res_o.armed_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/adc_frame_unpack_trigger_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_frame_unpack_trigger_detect
// Unpacks dual-channel converter words and runs a hysteresis trigger per
// channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per received
//   32-bit word plus its bank bit. The word packs two 14-bit samples in bits
//   31:18 and 17:4; they belong to channels 2*bank and 2*bank+1.
//   Output channel (out_valid_o / out_stall_i) carries one item per input:
//   both samples, a trigger pulse for each, and the bank echo.
//   Items pass through the input register, then the result register; one item
//   is accepted every cycle while the output is not stalled. The trigger
//   state is read and updated as an item moves from the input register to
//   the result register, so back-to-back items see each other's updates.
//   A stall on the output holds the result register; the input register then
//   holds too and in_stall_o rises once it is full.
//   Reset clears both registers' valid bits, all sample history to zero, all
//   arm bits, and loads the default thresholds (high 1638, low 819). The user
//   must write thresholds via cfg_we_i / cfg_idx_i / cfg_wdata_i only while
//   the block is idle (not enforced); index 0 = high threshold, 1 = low.
// ----------------------------------------------------------------------------
module adc_frame_unpack_trigger_detect
  import adcf_pkg::*;
(
  input  var logic                   clk_i,
  input  var logic                   rst_ni,
  // configuration
  input  var logic                   cfg_we_i,
  input  var logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  var logic [THRESH_BITS-1:0] cfg_wdata_i,
  // input items
  input  var logic                   in_valid_i,
  output logic                       in_stall_o,
  input  var logic [WORD_BITS-1:0]   rx_word_i,
  input  var logic                   bank_i,
  // result items
  output logic                       out_valid_o,
  input  var logic                   out_stall_i,
  output sample_t                    sample_first_o,
  output sample_t                    sample_second_o,
  output logic                       trigger_first_o,
  output logic                       trigger_second_o,
  output logic                       bank_out_o
);

  // Configuration registers
  thresh_t thresh_high_q, thresh_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_high_q <= THRESH_HIGH_RST;
      thresh_low_q  <= THRESH_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESH_HIGH: thresh_high_q <= cfg_wdata_i;
        REG_THRESH_LOW:  thresh_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage handshakes
  logic s1_valid_q;
  logic s2_valid_q;
  logic s2_load;
  logic s1_load;
  logic s1_move;

  assign s2_load    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_load;
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  // Input register
  logic [WORD_BITS-1:0] word_q;
  logic                 bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      word_q <= rx_word_i;
      bank_q <= bank_i;
    end
  end

  // Unpack the two samples; low bits below the second sample are dropped.
  sample_t samp0, samp1;
  chan_t   ch0, ch1;
  logic    ch0_ok, ch1_ok;

  assign samp0  = word_q[WORD_BITS-1 -: SAMPLE_BITS];
  assign samp1  = word_q[WORD_BITS-1-SAMPLE_BITS -: SAMPLE_BITS];
  assign ch0    = {bank_q, 1'b0};
  assign ch1    = {bank_q, 1'b1};
  assign ch0_ok = (int'(ch0) < NUM_CHANNELS);
  assign ch1_ok = (int'(ch1) < NUM_CHANNELS);

  // Per-channel trigger state
  sample_t prev_q  [NUM_CHANNELS];
  logic    armed_q [NUM_CHANNELS];

  chan_state_t st0, st1;
  trig_res_t   res0, res1;

  always_comb begin
    st0 = '0;
    st1 = '0;
    if (ch0_ok) begin
      st0.armed = armed_q[ch0];
      st0.prev  = prev_q[ch0];
    end
    if (ch1_ok) begin
      st1.armed = armed_q[ch1];
      st1.prev  = prev_q[ch1];
    end
  end

  adcf_trig_cell u_trig_first (
    .state_i       (st0),
    .sample_i      (samp0),
    .thresh_high_i (thresh_high_q),
    .thresh_low_i  (thresh_low_q),
    .res_o         (res0)
  );

  adcf_trig_cell u_trig_second (
    .state_i       (st1),
    .sample_i      (samp1),
    .thresh_high_i (thresh_high_q),
    .thresh_low_i  (thresh_low_q),
    .res_o         (res1)
  );

  // Commit channel state as the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_q[i]  <= '0;
        armed_q[i] <= 1'b0;
      end
    end else if (s1_move) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ch0_ok && (int'(ch0) == i)) begin
          prev_q[i]  <= samp0;
          armed_q[i] <= res0.armed_d;
        end else if (ch1_ok && (int'(ch1) == i)) begin
          prev_q[i]  <= samp1;
          armed_q[i] <= res1.armed_d;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      sample_first_o   <= samp0;
      sample_second_o  <= samp1;
      trigger_first_o  <= ch0_ok && res0.fire;
      trigger_second_o <= ch1_ok && res1.fire;
      bank_out_o       <= bank_q;
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule

`default_nettype wire
